// File: design/cfq_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and index helpers for the circular FIFO queue.
package cfq_pkg;

  localparam int DEPTH      = 64;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW         = $clog2(DEPTH + 1);
  localparam int WORD_W     = 32;
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  typedef logic [AW-1:0] idx_t;
  typedef logic [CW-1:0] cnt_t;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_DISP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVF   = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DISP
  } back_state_t;

  // decoded transaction handed from front to back
  typedef struct packed {
    op_t                      op;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

  // store port requests from the back end
  typedef struct packed {
    logic              we;
    idx_t              waddr;
    logic [WORD_W-1:0] wdata;
    idx_t              raddr;
  } ram_req_t;

  function automatic idx_t idx_inc(input idx_t i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
  endfunction

  function automatic idx_t idx_dec(input idx_t i);
    return (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
  endfunction

endpackage

// File: design/cfq_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module cfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/cfq_front.sv
`timescale 1ns / 1ps
// Front end: takes transactions, decodes the operation and queues commands.
module cfq_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_func,
  input  logic signed [cfq_pkg::WORD_W-1:0] in_push_value,
  output logic                              cmd_valid,
  output cfq_pkg::cmd_t                     cmd,
  input  logic                              cmd_pop
);
  import cfq_pkg::*;

  cmd_t                 q_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]   wptr_r, wptr_nxt;
  logic [CMDQ_AW-1:0]   rptr_r, rptr_nxt;
  logic [CMDQ_CW-1:0]   cnt_r, cnt_nxt;
  logic                 push, pop;
  cmd_t                 new_cmd;

  assign busy      = (cnt_r == CMDQ_CW'(CMDQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rptr_r];
  assign push      = start && !busy;
  assign pop       = cmd_pop && cmd_valid;

  always_comb begin
    new_cmd.op    = op_t'(in_func);
    new_cmd.value = in_push_value;
  end

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    if (push) begin
      wptr_nxt = (wptr_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wptr_r + CMDQ_AW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rptr_r + CMDQ_AW'(1);
    end
    cnt_nxt = cnt_r + CMDQ_CW'(push) - CMDQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= new_cmd;
    end
  end

endmodule

// File: design/cfq_back.sv
`timescale 1ns / 1ps
// Back end: ring pointers, store access and result sequencing.
module cfq_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cmd_valid,
  input  cfq_pkg::cmd_t                     cmd,
  output logic                              cmd_pop,
  output cfq_pkg::ram_req_t                 ram_req,
  input  logic [cfq_pkg::WORD_W-1:0]        ram_rdata,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic signed [cfq_pkg::WORD_W-1:0] out_word_out,
  output logic                              out_last
);
  import cfq_pkg::*;

  back_state_t              state_r, state_nxt;
  idx_t                     head_r, head_nxt;
  idx_t                     tail_r, tail_nxt;
  cnt_t                     cnt_r, cnt_nxt;
  cnt_t                     remain_r, remain_nxt;
  idx_t                     ptr_r, ptr_nxt;
  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic signed [WORD_W-1:0] out_word_r, out_word_nxt;
  logic                     out_last_r, out_last_nxt;
  logic                     empty;

  assign empty = (cnt_r == '0);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cnt_nxt        = cnt_r;
    remain_nxt     = remain_r;
    ptr_nxt        = ptr_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_OK;
    out_word_nxt   = '0;
    out_last_nxt   = 1'b1;
    cmd_pop        = 1'b0;
    ram_req.we     = 1'b0;
    ram_req.waddr  = tail_r;
    ram_req.wdata  = cmd.value;
    ram_req.raddr  = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            OP_ENQ: begin
              out_valid_nxt = 1'b1;
              if (cnt_r == CW'(DEPTH)) begin
                out_status_nxt = ST_OVF;
              end else begin
                ram_req.we = 1'b1;
                tail_nxt   = idx_inc(tail_r);
                cnt_nxt    = cnt_r + CW'(1);
              end
            end
            OP_DEQ: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                ram_req.raddr = head_r;
                head_nxt      = idx_inc(head_r);
                cnt_nxt       = cnt_r - CW'(1);
                state_nxt     = S_READ;
              end
            end
            OP_PEEK: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                ram_req.raddr = idx_dec(tail_r);
                state_nxt     = S_READ;
              end
            end
            OP_DISP: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                ram_req.raddr = head_r;
                ptr_nxt       = idx_inc(head_r);
                remain_nxt    = cnt_r;
                state_nxt     = S_DISP;
              end
            end
          endcase
        end
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = $signed(ram_rdata);
        state_nxt     = S_IDLE;
      end
      S_DISP: begin
        // read for the next word overlaps delivery of this one
        out_valid_nxt = 1'b1;
        out_word_nxt  = $signed(ram_rdata);
        out_last_nxt  = (remain_r == CW'(1));
        remain_nxt    = remain_r - CW'(1);
        ram_req.raddr = ptr_r;
        ptr_nxt       = idx_inc(ptr_r);
        if (remain_r == CW'(1)) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    remain_r     <= remain_nxt;
    ptr_r        <= ptr_nxt;
    out_status_r <= out_status_nxt;
    out_word_r   <= out_word_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_word_out = out_word_r;
  assign out_last     = out_last_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("fill count above depth");

  a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == CW'(DEPTH)) |-> (head_r == tail_r))
    else $error("head and tail disagree with fill count");

  a_disp_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |=> out_valid_r)
    else $error("display burst broken");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_last_r && out_word_r == '0))
    else $error("error result not final or carries data");

  a_disp_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DISP) |-> (remain_r != '0 && remain_r <= cnt_r))
    else $error("display count out of step");

endmodule

// File: design/circular_fifo_queue.sv
`timescale 1ns / 1ps
// Top level of the circular FIFO queue: front end, command queue, back end, store.
//
//  channel | ports                               | handshake
//  --------+-------------------------------------+-------------------------------
//  input   | in_func, in_push_value              | taken when start && !busy
//  result  | out_status, out_word_out, out_last  | one-cycle strobe on out_valid
//
// Enqueue: accept writes the command queue, then the back end registers the result.
//   Dequeue and peek add the registered read of the store before the result register.
// Display: fill-count results on consecutive cycles, the first by the same path as a dequeue;
//   the store read for word n+1 overlaps delivery of word n.
// The back end takes one command at a time; a two-entry command queue lets the
//   front keep taking transactions meanwhile, busy rises only when it is full.
// Reset (rst_n low, synchronous) empties the ring and the command queue; the store
//   itself is not cleared, since only written slots are ever read.
// Results cannot be stalled by the receiver.
module circular_fifo_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_func,
  input  logic signed [cfq_pkg::WORD_W-1:0] in_push_value,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic signed [cfq_pkg::WORD_W-1:0] out_word_out,
  output logic                              out_last
);
  import cfq_pkg::*;

  // front -> back command path
  logic              cmd_valid;
  cmd_t              cmd;
  logic              cmd_pop;

  // store port
  ram_req_t          ram_req;
  logic [WORD_W-1:0] ram_rdata;

  cfq_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_push_value (in_push_value),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  cfq_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .ram_req      (ram_req),
    .ram_rdata    (ram_rdata),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_word_out (out_word_out),
    .out_last     (out_last)
  );

  // ring storage, one write and one registered read per cycle
  cfq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule
